[design/rrfb_pkg.sv]
// ----------------------------------------------------------------------------
// rrfb_pkg
// Shared types, codes and arithmetic helpers for the rounded-rectangle
// fill and blend engine.
// ----------------------------------------------------------------------------
package rrfb_pkg;

    typedef logic signed [13:0] t_crd;

    typedef enum logic [1:0] {
        OP_DRAW  = 2'd0,
        OP_CLEAR = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        REG_FRAME_W     = 3'd0,
        REG_FRAME_H     = 3'd1,
        REG_CLIP_EN     = 3'd2,
        REG_CLIP_LEFT   = 3'd3,
        REG_CLIP_TOP    = 3'd4,
        REG_CLIP_SPAN_X = 3'd5,
        REG_CLIP_SPAN_Y = 3'd6,
        REG_CLEAR_COLOR = 3'd7
    } t_reg;

    localparam logic [8:0]  FRAME_DIM_RESET   = 9'd256;
    localparam logic [31:0] CLEAR_COLOR_RESET = 32'hFF1E1E1E;
    localparam logic [7:0]  ALPHA_OPAQUE      = 8'hFF;

    // exact floor(v / 255) for v below 255*256
    function automatic logic [7:0] div255(input logic [15:0] v);
        logic [16:0] t;
        t = 17'(v) + 17'(v[15:8]) + 17'd1;
        return t[15:8];
    endfunction

endpackage

[design/rrfb_ram.sv]
// ----------------------------------------------------------------------------
// rrfb_ram
// Generic single-clock RAM, one write port and one read port, registered
// read data.
// ----------------------------------------------------------------------------
module rrfb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[design/rounded_rect_fill_blend.sv]
// ----------------------------------------------------------------------------
// rounded_rect_fill_blend
// Rounded-rectangle fill with source-over blending into an on-chip
// framebuffer, plus frame clear and single-pixel read.
// ----------------------------------------------------------------------------
// One command at a time. A draw runs setup and prep, then visits each covered
// pixel (frame and clip applied), then drains the read-modify-write pipe:
// read at issue, distance and blend products next, corner test, /255 and
// write-back last. A clear runs prep, then writes each active-frame pixel. A
// read runs prep, a RAM read and a data capture. Command time is set by the
// single framebuffer write port, one pixel per cycle. The framebuffer is not
// cleared after reset; issue a clear before reading. A finished result waits
// in the output register while the next command is already taken.
module rounded_rect_fill_blend #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [1:0]          i_operation,
    input  logic signed [11:0]  i_x_pos,
    input  logic signed [11:0]  i_y_pos,
    input  logic [11:0]         i_rect_width,
    input  logic [11:0]         i_rect_height,
    input  logic [10:0]         i_corner_rad,
    input  logic [7:0]          i_red,
    input  logic [7:0]          i_green,
    input  logic [7:0]          i_blue,
    input  logic [7:0]          i_alpha,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [31:0]         o_pixel_value,
    output logic                o_read_valid,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [AW-1:0] ROW_STEP = AW'(MAX_WIDTH);
    localparam logic [12:0]   MAXW     = 13'(MAX_WIDTH);
    localparam logic [12:0]   MAXH     = 13'(MAX_HEIGHT);

    typedef enum logic [3:0] {
        S_IDLE, S_SETUP, S_PREP, S_DRAW, S_DRAIN, S_CLEAR, S_RD_MEM, S_RD_DATA, S_DONE
    } t_state;

    // configuration
    logic [8:0]  r_frame_w, r_frame_h, r_clip_sx, r_clip_sy;
    logic        r_clip_en;
    logic [7:0]  r_clip_left, r_clip_top;
    logic [31:0] r_clear_color;

    // command
    t_state             r_state;
    rrfb_pkg::t_op      r_op;
    rrfb_pkg::t_crd     r_x0, r_y0, r_x1, r_y1;
    rrfb_pkg::t_crd     r_xs, r_xe, r_ys, r_ye;
    rrfb_pkg::t_crd     r_xl, r_xr, r_yt, r_yb;
    logic [11:0]        r_w, r_h;
    logic [10:0]        r_rad;
    logic [21:0]        r_rad2;
    logic [2:0][7:0]    r_col;
    logic [2:0][7:0]    r_src;
    logic [2:0][15:0]   r_s255;
    logic [7:0]         r_alpha;

    // sweep
    rrfb_pkg::t_crd     r_px, r_py;
    logic [AW-1:0]      r_addr, r_row;

    // results
    logic [31:0] r_res_pix, r_out_pix;
    logic        r_res_rv, r_out_rv, r_out_valid;

    // pixel pipe
    logic               r_s1_v, r_s1_corner;
    logic [10:0]        r_s1_dx, r_s1_dy;
    logic [AW-1:0]      r_s1_addr;
    logic               r_s2_v, r_s2_corner;
    logic [21:0]        r_s2_dx2, r_s2_dy2;
    logic [2:0][15:0]   r_s2_sum;
    logic [AW-1:0]      r_s2_addr;

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    logic          cfg_wr;
    rrfb_pkg::t_reg cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = rrfb_pkg::t_reg'(paddr[4:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_w     <= rrfb_pkg::FRAME_DIM_RESET;
            r_frame_h     <= rrfb_pkg::FRAME_DIM_RESET;
            r_clip_en     <= 1'b0;
            r_clip_left   <= '0;
            r_clip_top    <= '0;
            r_clip_sx     <= '0;
            r_clip_sy     <= '0;
            r_clear_color <= rrfb_pkg::CLEAR_COLOR_RESET;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                rrfb_pkg::REG_FRAME_W:     r_frame_w     <= pwdata[8:0];
                rrfb_pkg::REG_FRAME_H:     r_frame_h     <= pwdata[8:0];
                rrfb_pkg::REG_CLIP_EN:     r_clip_en     <= pwdata[0];
                rrfb_pkg::REG_CLIP_LEFT:   r_clip_left   <= pwdata[7:0];
                rrfb_pkg::REG_CLIP_TOP:    r_clip_top    <= pwdata[7:0];
                rrfb_pkg::REG_CLIP_SPAN_X: r_clip_sx     <= pwdata[8:0];
                rrfb_pkg::REG_CLIP_SPAN_Y: r_clip_sy     <= pwdata[8:0];
                rrfb_pkg::REG_CLEAR_COLOR: r_clear_color <= pwdata;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            rrfb_pkg::REG_FRAME_W:     prdata = {23'b0, r_frame_w};
            rrfb_pkg::REG_FRAME_H:     prdata = {23'b0, r_frame_h};
            rrfb_pkg::REG_CLIP_EN:     prdata = {31'b0, r_clip_en};
            rrfb_pkg::REG_CLIP_LEFT:   prdata = {24'b0, r_clip_left};
            rrfb_pkg::REG_CLIP_TOP:    prdata = {24'b0, r_clip_top};
            rrfb_pkg::REG_CLIP_SPAN_X: prdata = {23'b0, r_clip_sx};
            rrfb_pkg::REG_CLIP_SPAN_Y: prdata = {23'b0, r_clip_sy};
            rrfb_pkg::REG_CLEAR_COLOR: prdata = r_clear_color;
        endcase
    end

    // ------------------------------------------------------------------
    // active frame size
    // ------------------------------------------------------------------
    logic [12:0]    fw13, fh13;
    rrfb_pkg::t_crd fw, fh;

    assign fw13 = ({4'b0, r_frame_w} > MAXW) ? MAXW : {4'b0, r_frame_w};
    assign fh13 = ({4'b0, r_frame_h} > MAXH) ? MAXH : {4'b0, r_frame_h};
    assign fw   = rrfb_pkg::t_crd'({1'b0, fw13});
    assign fh   = rrfb_pkg::t_crd'({1'b0, fh13});

    // ------------------------------------------------------------------
    // setup: bounds, radius clamp, premultiply
    // ------------------------------------------------------------------
    rrfb_pkg::t_crd su_x1, su_y1, su_xs, su_xe, su_ys, su_ye;
    rrfb_pkg::t_crd su_cl, su_ct, su_cr, su_cb;
    logic [10:0]    su_rad_a, su_rad_b;
    logic [2:0][7:0] su_src;

    always_comb begin
        su_x1 = r_x0 + rrfb_pkg::t_crd'({2'b00, r_w});
        su_y1 = r_y0 + rrfb_pkg::t_crd'({2'b00, r_h});
        su_rad_a = ({r_rad, 1'b0} > r_w) ? r_w[11:1] : r_rad;
        su_rad_b = ({su_rad_a, 1'b0} > r_h) ? r_h[11:1] : su_rad_a;
        su_xs = (r_x0 < 0) ? '0 : r_x0;
        su_ys = (r_y0 < 0) ? '0 : r_y0;
        su_xe = (su_x1 > fw) ? fw : su_x1;
        su_ye = (su_y1 > fh) ? fh : su_y1;
        su_cl = rrfb_pkg::t_crd'({6'b0, r_clip_left});
        su_ct = rrfb_pkg::t_crd'({6'b0, r_clip_top});
        su_cr = su_cl + rrfb_pkg::t_crd'({5'b0, r_clip_sx});
        su_cb = su_ct + rrfb_pkg::t_crd'({5'b0, r_clip_sy});
        if (r_clip_en) begin
            if (su_xs < su_cl) su_xs = su_cl;
            if (su_ys < su_ct) su_ys = su_ct;
            if (su_xe > su_cr) su_xe = su_cr;
            if (su_ye > su_cb) su_ye = su_cb;
        end
        for (int i = 0; i < 3; i++) begin
            su_src[i] = rrfb_pkg::div255({8'b0, r_col[i]} * {8'b0, r_alpha});
        end
    end

    // ------------------------------------------------------------------
    // prep and sweep
    // ------------------------------------------------------------------
    logic [AW-1:0]  base_addr;
    rrfb_pkg::t_crd rad_c, px_inc, py_inc;
    logic           area_empty, rd_hit, x_last, y_last;

    assign base_addr  = AW'(AW'(r_ys) * ROW_STEP) + AW'(r_xs);
    assign rad_c      = rrfb_pkg::t_crd'({3'b0, r_rad});
    assign area_empty = (r_xs >= r_xe) || (r_ys >= r_ye);
    assign rd_hit     = (r_x0 >= 0) && (r_y0 >= 0) && (r_x0 < fw) && (r_y0 < fh);
    assign px_inc     = r_px + rrfb_pkg::t_crd'(1);
    assign py_inc     = r_py + rrfb_pkg::t_crd'(1);
    assign x_last     = (px_inc == r_xe);
    assign y_last     = (py_inc == r_ye);

    assign o_stall = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_op      <= rrfb_pkg::t_op'(i_operation);
                        r_x0      <= rrfb_pkg::t_crd'(i_x_pos);
                        r_y0      <= rrfb_pkg::t_crd'(i_y_pos);
                        r_w       <= i_rect_width;
                        r_h       <= i_rect_height;
                        r_rad     <= i_corner_rad;
                        r_col     <= {i_red, i_green, i_blue};
                        r_alpha   <= i_alpha;
                        r_res_pix <= '0;
                        r_res_rv  <= 1'b0;
                        if (rrfb_pkg::t_op'(i_operation) == rrfb_pkg::OP_READ) begin
                            r_xs <= rrfb_pkg::t_crd'(i_x_pos);
                            r_ys <= rrfb_pkg::t_crd'(i_y_pos);
                        end else begin
                            r_xs <= '0;
                            r_ys <= '0;
                        end
                        r_xe <= fw;
                        r_ye <= fh;
                        unique case (rrfb_pkg::t_op'(i_operation))
                            rrfb_pkg::OP_DRAW:  r_state <= S_SETUP;
                            rrfb_pkg::OP_CLEAR: r_state <= S_PREP;
                            rrfb_pkg::OP_READ:  r_state <= S_PREP;
                            rrfb_pkg::OP_NONE:  r_state <= S_DONE;
                        endcase
                    end
                end
                S_SETUP: begin
                    r_x1    <= su_x1;
                    r_y1    <= su_y1;
                    r_xs    <= su_xs;
                    r_xe    <= su_xe;
                    r_ys    <= su_ys;
                    r_ye    <= su_ye;
                    r_rad   <= su_rad_b;
                    r_src   <= su_src;
                    r_state <= S_PREP;
                end
                S_PREP: begin
                    r_rad2 <= {11'b0, r_rad} * {11'b0, r_rad};
                    r_xl   <= r_x0 + rad_c;
                    r_xr   <= r_x1 - rad_c;
                    r_yt   <= r_y0 + rad_c;
                    r_yb   <= r_y1 - rad_c;
                    for (int i = 0; i < 3; i++) begin
                        r_s255[i] <= {r_src[i], 8'b0} - {8'b0, r_src[i]};
                    end
                    r_px   <= r_xs;
                    r_py   <= r_ys;
                    r_addr <= base_addr;
                    r_row  <= base_addr;
                    priority case (r_op)
                        rrfb_pkg::OP_DRAW:
                            r_state <= (area_empty || r_alpha == '0) ? S_DONE : S_DRAW;
                        rrfb_pkg::OP_CLEAR:
                            r_state <= area_empty ? S_DONE : S_CLEAR;
                        rrfb_pkg::OP_READ:
                            r_state <= rd_hit ? S_RD_MEM : S_DONE;
                        default:
                            r_state <= S_DONE;
                    endcase
                end
                S_DRAW, S_CLEAR: begin
                    if (x_last) begin
                        r_px   <= r_xs;
                        r_py   <= py_inc;
                        r_row  <= r_row + ROW_STEP;
                        r_addr <= r_row + ROW_STEP;
                    end else begin
                        r_px   <= px_inc;
                        r_addr <= r_addr + AW'(1);
                    end
                    if (x_last && y_last) begin
                        r_state <= (r_state == S_DRAW) ? S_DRAIN : S_DONE;
                    end
                end
                S_DRAIN: begin
                    if (!r_s1_v && !r_s2_v) begin
                        r_state <= S_DONE;
                    end
                end
                S_RD_MEM: begin
                    r_state <= S_RD_DATA;
                end
                S_RD_DATA: begin
                    r_res_pix <= ram_rdata;
                    r_res_rv  <= 1'b1;
                    r_state   <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || !i_stall) begin
                        r_out_valid <= 1'b1;
                        r_out_pix   <= r_res_pix;
                        r_out_rv    <= r_res_rv;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid       = r_out_valid;
    assign o_pixel_value = r_out_pix;
    assign o_read_valid  = r_out_rv;

    // ------------------------------------------------------------------
    // pixel read-modify-write pipe
    // ------------------------------------------------------------------
    logic           issue, c_left, c_right, c_top, c_bot, c_corner;
    rrfb_pkg::t_crd c_dx, c_dy;
    logic [31:0]    ram_rdata;
    logic [7:0]     inv_alpha;
    logic [22:0]    dist2;
    logic           skip;
    logic [31:0]    blend_word, src_word;

    assign issue    = (r_state == S_DRAW);
    assign c_left   = (r_px < r_xl);
    assign c_right  = (r_px >= r_xr);
    assign c_top    = (r_py < r_yt);
    assign c_bot    = (r_py >= r_yb);
    assign c_corner = (c_left || c_right) && (c_top || c_bot);
    assign c_dx     = c_left ? (r_xl - r_px) : (px_inc - r_xr);
    assign c_dy     = c_top ? (r_yt - r_py) : (py_inc - r_yb);
    assign inv_alpha = rrfb_pkg::ALPHA_OPAQUE - r_alpha;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else begin
            r_s1_v <= issue;
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_corner <= c_corner;
        r_s1_dx     <= c_dx[10:0];
        r_s1_dy     <= c_dy[10:0];
        r_s1_addr   <= r_addr;
        r_s2_corner <= r_s1_corner;
        r_s2_dx2    <= {11'b0, r_s1_dx} * {11'b0, r_s1_dx};
        r_s2_dy2    <= {11'b0, r_s1_dy} * {11'b0, r_s1_dy};
        r_s2_addr   <= r_s1_addr;
        for (int i = 0; i < 3; i++) begin
            r_s2_sum[i] <= ({8'b0, ram_rdata[8*i +: 8]} * {8'b0, inv_alpha}) + r_s255[i];
        end
    end

    assign dist2      = {1'b0, r_s2_dx2} + {1'b0, r_s2_dy2};
    assign skip       = r_s2_corner && (dist2 > {1'b0, r_rad2});
    assign src_word   = {r_alpha, r_src[2], r_src[1], r_src[0]};
    assign blend_word = (r_alpha == rrfb_pkg::ALPHA_OPAQUE) ? src_word :
                        {rrfb_pkg::ALPHA_OPAQUE, rrfb_pkg::div255(r_s2_sum[2]),
                         rrfb_pkg::div255(r_s2_sum[1]), rrfb_pkg::div255(r_s2_sum[0])};

    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr;
    logic [31:0]   ram_wdata;

    always_comb begin
        if (r_state == S_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = r_addr;
            ram_wdata = r_clear_color;
        end else begin
            ram_we    = r_s2_v && !skip;
            ram_waddr = r_s2_addr;
            ram_wdata = blend_word;
        end
    end

    assign ram_re = issue || (r_state == S_RD_MEM);

    rrfb_ram #(
        .WIDTH(32),
        .DEPTH(DEPTH)
    ) u_frame (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_addr),
        .o_rdata (ram_rdata)
    );

`ifndef ASSERT_OFF
    a_pipe_only_in_draw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_v |-> (r_state == S_DRAW || r_state == S_DRAIN))
        else $error("pixel pipe busy outside draw");

    a_clear_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> (r_px >= 0 && r_py >= 0 && r_px < r_xe && r_py < r_ye))
        else $error("clear sweep left the frame");

    a_done_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_out_valid && i_stall) |=> (r_state == S_DONE))
        else $error("result overwrote a pending transfer");

    a_zero_without_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_read_valid) |-> (o_pixel_value == '0))
        else $error("nonzero pixel without a read hit");
`endif

endmodule

[tb/rrfb_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrfb_checker
// Watches the command, reply and register ports of the rounded-rectangle
// fill/blend engine. Keeps its own copy of the registers and the
// framebuffer, works out the reply of every accepted command and compares
// the replies in order, field by field.
// ----------------------------------------------------------------------------
module rrfb_checker #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               o_stall,
    input  logic [1:0]         i_operation,
    input  logic signed [11:0] i_x_pos,
    input  logic signed [11:0] i_y_pos,
    input  logic [11:0]        i_rect_width,
    input  logic [11:0]        i_rect_height,
    input  logic [10:0]        i_corner_rad,
    input  logic [7:0]         i_red,
    input  logic [7:0]         i_green,
    input  logic [7:0]         i_blue,
    input  logic [7:0]         i_alpha,
    input  logic               o_valid,
    input  logic               i_stall,
    input  logic [31:0]        o_pixel_value,
    input  logic               o_read_valid,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    input  logic               pready,
    output int                 mismatch_cnt,
    output int                 outstanding
);
    import rrfb_pkg::*;

    typedef struct {
        logic [31:0] pixel;
        logic        hit;
    } t_reply;

    logic [31:0] fb_mem [MAX_WIDTH*MAX_HEIGHT];
    t_reply      reply_q [$];

    logic [8:0]  frame_w;
    logic [8:0]  frame_h;
    logic        clip_on;
    logic [7:0]  clip_x0;
    logic [7:0]  clip_y0;
    logic [8:0]  clip_w;
    logic [8:0]  clip_h;
    logic [31:0] fill_word;

    function automatic int active_w();
        return (frame_w > MAX_WIDTH) ? MAX_WIDTH : int'(frame_w);
    endfunction

    function automatic int active_h();
        return (frame_h > MAX_HEIGHT) ? MAX_HEIGHT : int'(frame_h);
    endfunction

    function automatic logic [31:0] blend_over(logic [31:0] dst, logic [31:0] src);
        int sa;
        int s;
        int d;
        logic [31:0] res;
        sa = src[31:24];
        if (sa == 0) return dst;
        if (sa == 255) return src;
        res = 32'hFF00_0000;
        for (int sh = 0; sh < 24; sh += 8) begin
            s = src[sh +: 8];
            d = dst[sh +: 8];
            res[sh +: 8] = 8'((s * 255 + d * (255 - sa)) / 255);
        end
        return res;
    endfunction

    function automatic void paint_rect(int x0, int y0, int w, int h, int rad,
                                       int r, int g, int b, int a);
        int x1, y1, xs, xe, ys, ye, dx, dy, x, y, idx;
        int cl, ct;
        bit lf, rt, tp, bt;
        logic [31:0] src;
        if (a == 0) return;
        x1 = x0 + w;
        y1 = y0 + h;
        if (2 * rad > w) rad = w / 2;
        if (2 * rad > h) rad = h / 2;
        src = {8'(a), 8'(r * a / 255), 8'(g * a / 255), 8'(b * a / 255)};
        xs = (x0 < 0) ? 0 : x0;
        ys = (y0 < 0) ? 0 : y0;
        xe = (x1 > active_w()) ? active_w() : x1;
        ye = (y1 > active_h()) ? active_h() : y1;
        if (clip_on) begin
            cl = clip_x0;
            ct = clip_y0;
            if (xs < cl) xs = cl;
            if (ys < ct) ys = ct;
            if (xe > cl + int'(clip_w)) xe = cl + int'(clip_w);
            if (ye > ct + int'(clip_h)) ye = ct + int'(clip_h);
        end
        for (y = ys; y < ye; y++) begin
            for (x = xs; x < xe; x++) begin
                lf = x < x0 + rad;
                rt = x >= x1 - rad;
                tp = y < y0 + rad;
                bt = y >= y1 - rad;
                if ((lf || rt) && (tp || bt)) begin
                    dx = lf ? x0 + rad - x : x - (x1 - rad - 1);
                    dy = tp ? y0 + rad - y : y - (y1 - rad - 1);
                    if (dx > 0 && dy > 0 && dx * dx + dy * dy > rad * rad) continue;
                end
                idx = y * MAX_WIDTH + x;
                fb_mem[idx] = blend_over(fb_mem[idx], src);
            end
        end
    endfunction

    function automatic t_reply predict_reply(t_op op, int xp, int yp, int w, int h,
                                             int rad, int r, int g, int b, int a);
        t_reply rep;
        int x, y;
        rep.pixel = '0;
        rep.hit   = 1'b0;
        case (op)
            OP_DRAW: begin
                paint_rect(xp, yp, w, h, rad, r, g, b, a);
            end
            OP_CLEAR: begin
                for (y = 0; y < active_h(); y++)
                    for (x = 0; x < active_w(); x++)
                        fb_mem[y * MAX_WIDTH + x] = fill_word;
            end
            OP_READ: begin
                if (xp >= 0 && yp >= 0 && xp < active_w() && yp < active_h()) begin
                    rep.pixel = fb_mem[yp * MAX_WIDTH + xp];
                    rep.hit   = 1'b1;
                end
            end
            default: ;
        endcase
        return rep;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t rrfb_checker: %s got %h want %h", $time, what, got, want);
        mismatch_cnt++;
    endtask

    always @(posedge i_clk) begin
        t_reply want;
        if (!i_rst_n) begin
            frame_w   = FRAME_DIM_RESET;
            frame_h   = FRAME_DIM_RESET;
            clip_on   = 1'b0;
            clip_x0   = '0;
            clip_y0   = '0;
            clip_w    = '0;
            clip_h    = '0;
            fill_word = CLEAR_COLOR_RESET;
            reply_q.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (t_reg'(paddr[4:2]))
                    REG_FRAME_W:     frame_w   = pwdata[8:0];
                    REG_FRAME_H:     frame_h   = pwdata[8:0];
                    REG_CLIP_EN:     clip_on   = pwdata[0];
                    REG_CLIP_LEFT:   clip_x0   = pwdata[7:0];
                    REG_CLIP_TOP:    clip_y0   = pwdata[7:0];
                    REG_CLIP_SPAN_X: clip_w    = pwdata[8:0];
                    REG_CLIP_SPAN_Y: clip_h    = pwdata[8:0];
                    REG_CLEAR_COLOR: fill_word = pwdata;
                    default: ;
                endcase
            end
            // replies first: a reply can never belong to a command taken at the same edge
            if (o_valid && !i_stall) begin
                if (reply_q.size() == 0) begin
                    report_mismatch("reply with no command pending", o_pixel_value, '0);
                end else begin
                    want = reply_q.pop_front();
                    if (o_pixel_value !== want.pixel)
                        report_mismatch("pixel_value", o_pixel_value, want.pixel);
                    if (o_read_valid !== want.hit)
                        report_mismatch("read_valid", 32'(o_read_valid), 32'(want.hit));
                end
            end
            if (i_valid && !o_stall)
                reply_q.push_back(predict_reply(t_op'(i_operation), i_x_pos, i_y_pos,
                                                i_rect_width, i_rect_height, i_corner_rad,
                                                i_red, i_green, i_blue, i_alpha));
        end
        outstanding <= reply_q.size();
    end

endmodule

[tb/tb_rounded_rect_fill_blend.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rounded_rect_fill_blend
// Drives draw, clear, read and no-op commands into the fill/blend engine under
// random idling and back-pressure, reprograms frame and clip registers
// between phases, and reports the verdict from the checker's count.
// ----------------------------------------------------------------------------
module tb_rounded_rect_fill_blend;
    import rrfb_pkg::*;

    localparam int     FB_W        = 256;
    localparam int     FB_H        = 256;
    localparam int     RANDOM_CMDS = 140;
    localparam int     LONG_HOLD   = 1500;
    localparam int     TAIL_CYCLES = 20;
    localparam longint TIMEOUT_NS  = 100_000_000;

    typedef struct {
        t_op         op;
        logic [11:0] x;
        logic [11:0] y;
        logic [11:0] w;
        logic [11:0] h;
        logic [10:0] rad;
        logic [7:0]  r;
        logic [7:0]  g;
        logic [7:0]  b;
        logic [7:0]  a;
    } t_cmd;

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               i_valid       = 1'b0;
    logic               o_stall;
    logic [1:0]         i_operation   = '0;
    logic signed [11:0] i_x_pos       = '0;
    logic signed [11:0] i_y_pos       = '0;
    logic [11:0]        i_rect_width  = '0;
    logic [11:0]        i_rect_height = '0;
    logic [10:0]        i_corner_rad  = '0;
    logic [7:0]         i_red         = '0;
    logic [7:0]         i_green       = '0;
    logic [7:0]         i_blue        = '0;
    logic [7:0]         i_alpha       = '0;
    logic               o_valid;
    logic               i_stall       = 1'b0;
    logic [31:0]        o_pixel_value;
    logic               o_read_valid;
    logic               psel          = 1'b0;
    logic               penable       = 1'b0;
    logic               pwrite        = 1'b0;
    logic [4:0]         paddr         = '0;
    logic [31:0]        pwdata        = '0;
    logic [31:0]        prdata;
    logic               pready;
    int                 mismatch_cnt;
    int                 outstanding;

    bit hold_req  = 1'b0;
    bit gaps_off  = 1'b0;
    bit big_frame = 1'b1;
    int fb_w      = FB_W;
    int fb_h      = FB_H;
    int last_x, last_y, last_w, last_h;
    int issued;

    rounded_rect_fill_blend #(.MAX_WIDTH(FB_W), .MAX_HEIGHT(FB_H)) uut (.*);

    rrfb_checker #(.MAX_WIDTH(FB_W), .MAX_HEIGHT(FB_H)) u_checker (.*);

    always #5 i_clk = ~i_clk;

    initial begin
        #(TIMEOUT_NS);
        $display("tb: failure");
        $finish;
    end

    // reply side back-pressure
    initial begin
        int run_left;
        int hold_left;
        int sel;
        bit stall_now;
        run_left  = 0;
        hold_left = 0;
        stall_now = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = LONG_HOLD - 1;
                i_stall <= 1'b1;
            end else begin
                if (run_left == 0) begin
                    sel = $urandom_range(0, 99);
                    if (sel < 50) begin
                        stall_now = 1'b0;
                        run_left  = $urandom_range(1, 8);
                    end else if (sel < 62) begin
                        stall_now = 1'b0;
                        run_left  = $urandom_range(50, 300);
                    end else if (sel < 95) begin
                        stall_now = 1'b1;
                        run_left  = $urandom_range(1, 4);
                    end else begin
                        stall_now = 1'b1;
                        run_left  = $urandom_range(20, 80);
                    end
                end
                run_left--;
                i_stall <= stall_now;
            end
        end
    end

    function automatic int pick_gap();
        int sel;
        if (gaps_off) return 0;
        sel = $urandom_range(0, 99);
        if (sel < 55) return 0;
        if (sel < 88) return $urandom_range(1, 4);
        if (sel < 98) return $urandom_range(5, 20);
        return $urandom_range(40, 150);
    endfunction

    function automatic t_cmd make_cmd(t_op op, int x, int y, int w, int h, int rad,
                                      logic [31:0] argb);
        t_cmd c;
        c.op  = op;
        c.x   = 12'(x);
        c.y   = 12'(y);
        c.w   = 12'(w);
        c.h   = 12'(h);
        c.rad = 11'(rad);
        {c.a, c.r, c.g, c.b} = argb;
        return c;
    endfunction

    function automatic logic [11:0] pick_coord(int lim);
        if ($urandom_range(0, 99) < 85) return 12'($urandom_range(0, lim + 20) - 10);
        return 12'($urandom());
    endfunction

    function automatic t_cmd rand_cmd();
        t_cmd c;
        int sel;
        sel = $urandom_range(0, 99);
        c = make_cmd(OP_READ, 0, 0, $urandom(), $urandom(), $urandom(), $urandom());
        if (sel < 50) begin
            c.op = OP_DRAW;
            c.x  = pick_coord(fb_w);
            c.y  = pick_coord(fb_h);
            if (!big_frame && $urandom_range(0, 99) < 15) begin
                c.w = 12'($urandom());
                c.h = 12'($urandom());
            end else begin
                c.w = 12'($urandom_range(0, big_frame ? 48 : 40));
                c.h = 12'($urandom_range(0, big_frame ? 48 : 40));
            end
            sel = $urandom_range(0, 99);
            if (sel < 15)      c.rad = 11'($urandom());
            else if (sel < 40) c.rad = 11'($urandom_range(0, c.w / 2 + 2));
            else               c.rad = 11'($urandom_range(0, 12));
            sel = $urandom_range(0, 99);
            if (sel < 10)      c.a = 8'h00;
            else if (sel < 35) c.a = 8'hFF;
            else               c.a = 8'($urandom_range(1, 254));
            last_x = $signed(c.x);
            last_y = $signed(c.y);
            last_w = c.w;
            last_h = c.h;
        end else if (sel < 85) begin
            sel = $urandom_range(0, 99);
            if (sel < 55 && last_w > 0 && last_h > 0) begin
                c.x = 12'(last_x + int'($urandom_range(0, last_w - 1)));
                c.y = 12'(last_y + int'($urandom_range(0, last_h - 1)));
            end else if (sel < 90) begin
                c.x = 12'($urandom_range(0, fb_w));
                c.y = 12'($urandom_range(0, fb_h));
            end else begin
                c.x = 12'($urandom());
                c.y = 12'($urandom());
            end
        end else if (sel < 93) begin
            c.op = big_frame ? OP_READ : OP_CLEAR;
        end else begin
            c.op = OP_NONE;
        end
        return c;
    endfunction

    task automatic send_cmd(t_cmd c);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_operation   <= c.op;
        i_x_pos       <= c.x;
        i_y_pos       <= c.y;
        i_rect_width  <= c.w;
        i_rect_height <= c.h;
        i_corner_rad  <= c.rad;
        i_red         <= c.r;
        i_green       <= c.g;
        i_blue        <= c.b;
        i_alpha       <= c.a;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
    endtask

    task automatic write_reg(t_reg idx, logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
    endtask

    task automatic configure(int w, int h, bit clip, int cl, int ct, int cw, int ch,
                             logic [31:0] fill);
        write_reg(REG_FRAME_W, w);
        write_reg(REG_FRAME_H, h);
        write_reg(REG_CLIP_EN, clip);
        write_reg(REG_CLIP_LEFT, cl);
        write_reg(REG_CLIP_TOP, ct);
        write_reg(REG_CLIP_SPAN_X, cw);
        write_reg(REG_CLIP_SPAN_Y, ch);
        write_reg(REG_CLEAR_COLOR, fill);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        fb_w      = (w > FB_W) ? FB_W : w;
        fb_h      = (h > FB_H) ? FB_H : h;
        big_frame = fb_w * fb_h > 4096;
        last_w    = 0;
        last_h    = 0;
    endtask

    task automatic random_setup();
        int w, h, wl, hl, sel;
        sel = $urandom_range(0, 99);
        if (sel < 75) begin
            w = $urandom_range(1, 64);
            h = $urandom_range(1, 64);
        end else if (sel < 93) begin
            w = $urandom_range(65, 256);
            h = $urandom_range(65, 256);
        end else begin
            w = $urandom_range(257, 511);
            h = $urandom_range(1, 511);
        end
        wl = (w > 256) ? 255 : w - 1;
        hl = (h > 256) ? 255 : h - 1;
        configure(w, h, $urandom_range(0, 1),
                  ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, wl),
                  ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, hl),
                  $urandom_range(0, 256), $urandom_range(0, 256), $urandom());
    endtask

    task automatic run_phase(int n, bit clear_first);
        t_cmd c;
        if (clear_first && !big_frame) begin
            send_cmd(make_cmd(OP_CLEAR, 0, 0, 0, 0, 0, 0));
            issued++;
        end
        repeat (n) begin
            c = rand_cmd();
            send_cmd(c);
            if (c.op != OP_NONE) issued++;
        end
        drain();
    endtask

    initial begin
        issued = 0;
        last_w = 0;
        last_h = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset register values: full frame, no clip
        send_cmd(make_cmd(OP_CLEAR, 0, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(OP_READ, 255, 255, 0, 0, 0, 0));
        send_cmd(make_cmd(OP_READ, 256, 3, 0, 0, 0, 0));
        send_cmd(make_cmd(OP_READ, -1, -1, 0, 0, 0, 0));
        send_cmd(make_cmd(OP_READ, -2048, 2047, 0, 0, 0, 0));
        send_cmd(make_cmd(OP_READ, 2047, -2048, 0, 0, 0, 0));
        send_cmd(make_cmd(OP_DRAW, 10, 10, 20, 12, 0, 32'hFF10_2030));
        send_cmd(make_cmd(OP_DRAW, 12, 8, 24, 16, 6, 32'h80F0_A050));
        send_cmd(make_cmd(OP_READ, 12, 8, 0, 0, 0, 0));
        send_cmd(make_cmd(OP_READ, 20, 14, 0, 0, 0, 0));
        send_cmd(make_cmd(OP_DRAW, 0, 0, 50, 50, 3, 32'h00FF_FFFF));
        send_cmd(make_cmd(OP_DRAW, 5, 5, 0, 30, 0, 32'hFF00_FF00));
        send_cmd(make_cmd(OP_DRAW, 5, 5, 30, 0, 0, 32'hFF00_FF00));
        send_cmd(make_cmd(OP_DRAW, 40, 40, 15, 9, 2047, 32'h7F33_CC99));
        send_cmd(make_cmd(OP_READ, 40, 40, 0, 0, 0, 0));
        send_cmd(make_cmd(OP_DRAW, -5, -7, 20, 20, 8, 32'hC000_0000));
        send_cmd(make_cmd(OP_DRAW, 250, 250, 30, 30, 10, 32'hFEFF_FFFF));
        send_cmd(make_cmd(OP_READ, 252, 252, 0, 0, 0, 0));
        send_cmd(make_cmd(OP_DRAW, -2048, -2048, 4095, 4095, 2047, 32'h01FF_FFFF));
        send_cmd(make_cmd(OP_NONE, 100, 100, 10, 10, 1, 32'hFFFF_FFFF));
        send_cmd(make_cmd(OP_READ, 128, 128, 0, 0, 0, 0));
        drain();

        // reply side held off while commands keep coming
        hold_req = 1'b1;
        gaps_off = 1'b1;
        repeat (10) begin
            send_cmd(make_cmd(OP_READ, $urandom_range(0, 255), $urandom_range(0, 255),
                              0, 0, 0, 0));
            issued++;
        end
        gaps_off = 1'b0;
        drain();

        configure(40, 30, 1, 8, 6, 20, 10, 32'h0000_0000);
        run_phase(12, 1'b1);
        configure(1, 1, 0, 0, 0, 0, 0, 32'hFFFF_FFFF);
        run_phase(8, 1'b1);
        configure(256, 256, 1, 255, 255, 256, 256, 32'hFF80_4020);
        send_cmd(make_cmd(OP_DRAW, 250, 250, 10, 10, 0, 32'hFF12_3456));
        send_cmd(make_cmd(OP_READ, 255, 255, 0, 0, 0, 0));
        send_cmd(make_cmd(OP_READ, 254, 255, 0, 0, 0, 0));
        issued += 3;
        run_phase(6, 1'b0);
        configure(64, 64, 1, 10, 10, 0, 0, 32'h1234_5678);
        send_cmd(make_cmd(OP_DRAW, 0, 0, 64, 64, 0, 32'hFF00_00FF));
        send_cmd(make_cmd(OP_READ, 10, 10, 0, 0, 0, 0));
        issued += 2;
        run_phase(6, 1'b0);
        configure(511, 300, 0, 0, 0, 256, 256, 32'hFF00_0000);
        run_phase(8, 1'b0);
        configure(64, 48, 1, 0, 0, 256, 256, 32'hFFFF_0000);
        run_phase(8, 1'b1);

        while (issued < RANDOM_CMDS) begin
            random_setup();
            gaps_off = ($urandom_range(0, 4) == 0);
            run_phase($urandom_range(6, 14), $urandom_range(0, 1));
        end
        gaps_off = 1'b0;

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_cnt == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

[rounded_rect_fill_blend.f]
design/rrfb_pkg.sv
design/rrfb_ram.sv
design/rounded_rect_fill_blend.sv
tb/rrfb_checker.sv
tb/tb_rounded_rect_fill_blend.sv
